[hw/rtl/psu_pkg.sv]
// Shared types and constants for the PNG scanline unfilter.
// Used by psu_ctrl, psu_recon and png_scanline_unfilter.
`timescale 1ns / 1ps

package psu_pkg;

  localparam int RAW_W  = 8;
  localparam int ROWB_W = 14;
  localparam int BPP_W  = 4;
  localparam int PIX_W  = 8;

  localparam int DEF_MAX_ROW_BYTES       = 8192;
  localparam int DEF_MAX_BYTES_PER_PIXEL = 8;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  typedef struct packed {
    logic [RAW_W-1:0]  raw_byte;
    logic              new_pass;
    logic [ROWB_W-1:0] row_bytes;
  } psu_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_byte;
    logic             row_end;
  } psu_out_t;

  // One data byte handed from row sequencing to reconstruction
  typedef struct packed {
    logic [RAW_W-1:0] raw_byte;
    filt_t            filt;
    logic             no_above;
    logic             left_ok;
    logic             row_end;
  } psu_entry_t;

endpackage

[hw/rtl/psu_row_mem.sv]
// Row-above buffer: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module psu_row_mem #(
  parameter int DEPTH = 8192,
  parameter int DW    = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/psu_ctrl.sv]
// Row sequencing: filter byte decode, byte position, row length, pixel stride.
// Depends on psu_pkg.
`timescale 1ns / 1ps

module psu_ctrl #(
  parameter int MAX_ROW_BYTES       = 8192,
  parameter int MAX_BYTES_PER_PIXEL = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  psu_pkg::psu_in_t                    in_data,
  output logic                                in_ready,
  input  logic                                cfg_we,
  input  logic [psu_pkg::BPP_W-1:0]           cfg_wdata,
  input  logic                                s1_free,
  output logic                                push,
  output psu_pkg::psu_entry_t                 entry,
  output logic [$clog2(MAX_ROW_BYTES)-1:0]    pos,
  output logic [((MAX_BYTES_PER_PIXEL > 1) ?
                 $clog2(MAX_BYTES_PER_PIXEL) : 1)-1:0] bpp_idx
);

  import psu_pkg::*;

  localparam int POS_W = $clog2(MAX_ROW_BYTES);
  localparam int IDX_W = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;

  logic              await_r, await_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  last_r, last_nxt;
  filt_t             filt_r, filt_nxt;
  logic              noabove_r, noabove_nxt;
  logic [BPP_W-1:0]  bpp_r, bpp_nxt;
  logic              acc;
  logic [31:0]       len;

  assign in_ready = s1_free;
  assign acc      = in_valid && in_ready;
  assign push     = acc && !await_r;
  assign pos      = pos_r;
  assign bpp_idx  = IDX_W'(bpp_r - BPP_W'(1));

  always_comb begin
    entry.raw_byte = in_data.raw_byte;
    entry.filt     = filt_r;
    entry.no_above = noabove_r;
    entry.left_ok  = 32'(pos_r) >= 32'(bpp_r);
    entry.row_end  = (pos_r == last_r);
  end

  // stride saturates into 1..MAX_BYTES_PER_PIXEL
  always_comb begin
    bpp_nxt = bpp_r;
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        bpp_nxt = BPP_W'(1);
      end else if (32'(cfg_wdata) > MAX_BYTES_PER_PIXEL) begin
        bpp_nxt = BPP_W'(MAX_BYTES_PER_PIXEL);
      end else begin
        bpp_nxt = cfg_wdata;
      end
    end
  end

  always_comb begin
    await_nxt   = await_r;
    pos_nxt     = pos_r;
    last_nxt    = last_r;
    filt_nxt    = filt_r;
    noabove_nxt = noabove_r;
    len         = 32'(in_data.row_bytes);
    if (len == 32'd0) begin
      len = 32'd1;
    end else if (len > MAX_ROW_BYTES) begin
      len = 32'(MAX_ROW_BYTES);
    end
    if (acc) begin
      if (await_r) begin
        await_nxt   = 1'b0;
        pos_nxt     = '0;
        last_nxt    = POS_W'(len - 32'd1);
        noabove_nxt = in_data.new_pass;
        if (in_data.raw_byte <= RAW_W'(FILT_PAETH)) begin
          filt_nxt = filt_t'(in_data.raw_byte[2:0]);
        end else begin
          filt_nxt = FILT_NONE;  // unknown types pass data through
        end
      end else if (pos_r == last_r) begin
        await_nxt = 1'b1;
        pos_nxt   = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r   <= 1'b1;
      pos_r     <= '0;
      last_r    <= '0;
      filt_r    <= FILT_NONE;
      noabove_r <= 1'b1;
      bpp_r     <= BPP_W'(1);
    end else begin
      await_r   <= await_nxt;
      pos_r     <= pos_nxt;
      last_r    <= last_nxt;
      filt_r    <= filt_nxt;
      noabove_r <= noabove_nxt;
      bpp_r     <= bpp_nxt;
    end
  end

  a_pos_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    !await_r |-> pos_r <= last_r)
    else $error("byte position past end of row");

  a_row_end_await: assert property (@(posedge clk) disable iff (!rst_n)
    (push && entry.row_end) |=> await_r)
    else $error("row end did not return to filter byte");

  a_filter_start: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && await_r) |=> (!await_r && pos_r == '0))
    else $error("filter byte did not start a row at position zero");

endmodule

[hw/rtl/psu_recon.sv]
// Reconstruction stage: None/Sub/Up/Average/Paeth against left, above, above-left,
// plus the left history and the output register. Depends on psu_pkg.
`timescale 1ns / 1ps

module psu_recon #(
  parameter int MAX_ROW_BYTES       = 8192,
  parameter int MAX_BYTES_PER_PIXEL = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  psu_pkg::psu_entry_t                 entry,
  input  logic [$clog2(MAX_ROW_BYTES)-1:0]    pos,
  input  logic [((MAX_BYTES_PER_PIXEL > 1) ?
                 $clog2(MAX_BYTES_PER_PIXEL) : 1)-1:0] bpp_idx,
  input  logic [psu_pkg::PIX_W-1:0]           above_byte,
  output logic                                s1_free,
  output logic                                mem_we,
  output logic [$clog2(MAX_ROW_BYTES)-1:0]    mem_waddr,
  output logic [psu_pkg::PIX_W-1:0]           mem_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output psu_pkg::psu_out_t                   out_data
);

  import psu_pkg::*;

  localparam int POS_W = $clog2(MAX_ROW_BYTES);

  logic             s1_valid_r;
  psu_entry_t       s1_r;
  logic [POS_W-1:0] s1_pos_r;
  logic             out_valid_r;
  psu_out_t         out_data_r;
  logic [PIX_W-1:0] left_r [MAX_BYTES_PER_PIXEL];
  logic [PIX_W-1:0] ul_r   [MAX_BYTES_PER_PIXEL];

  logic             out_free, adv;
  logic [PIX_W-1:0] a, b, c, pred, res;
  logic [PIX_W:0]   avg_sum;
  logic signed [PIX_W+1:0] da, db, dc, pa, pb, pc;

  assign out_free = !out_valid_r || out_ready;
  assign adv      = s1_valid_r && out_free;
  assign s1_free  = !s1_valid_r || out_free;

  always_comb begin
    b = s1_r.no_above ? '0 : above_byte;
    a = s1_r.left_ok ? left_r[bpp_idx] : '0;
    c = (s1_r.left_ok && !s1_r.no_above) ? ul_r[bpp_idx] : '0;
    avg_sum = {1'b0, a} + {1'b0, b};
    // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = da + db;
    pa = (da < 0) ? -da : da;
    pb = (db < 0) ? -db : db;
    pc = (dc < 0) ? -dc : dc;
    case (s1_r.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[PIX_W:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:    pred = '0;
    endcase
    res = s1_r.raw_byte + pred;
  end

  assign mem_we    = adv;
  assign mem_waddr = s1_pos_r;
  assign mem_wdata = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && push) begin
      s1_r     <= entry;
      s1_pos_r <= pos;
    end
  end

  // history entries are only read once they hold bytes of the current row
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = MAX_BYTES_PER_PIXEL - 1; k > 0; k--) begin
        left_r[k] <= left_r[k-1];
        ul_r[k]   <= ul_r[k-1];
      end
      left_r[0] <= res;
      ul_r[0]   <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.pixel_byte <= res;
      out_data_r.row_end    <= s1_r.row_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("reconstructed byte lost on the way to the output register");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> s1_free)
    else $error("data byte pushed into an occupied stage");

endmodule

[hw/rtl/png_scanline_unfilter.sv]
// PNG scanline filter reconstruction, one byte per clock while out_ready stays high.
// Depends on psu_pkg, psu_ctrl, psu_recon and psu_row_mem.
//
// Input channel (in_valid/in_ready/in_data): the inflated image stream. The
// first byte of each row is the filter type, sampled together with new_pass
// and row_bytes; it is consumed and produces no output transaction. Every
// following byte produces one output transaction (out_valid/out_ready/
// out_data) carrying the reconstructed byte, with row_end set on the last
// byte of the row. cfg_we/cfg_wdata set bytes_per_pixel; write only while idle.
// Datapath: an accepted data byte is registered into the reconstruction stage
// together with its row-buffer read, then reconstructed into the output register.
// Throughput: one transaction per cycle while out_ready stays high; the row
// buffer does at most one read and one write each cycle. While out_ready is
// low a completed byte waits in the output register, one more waits in the
// reconstruction stage, and in_ready drops.
// Reset: row sequencing returns to expecting a filter byte, bytes_per_pixel
// returns to 1. The row buffer is not cleared; the first row of an image must
// be flagged with new_pass.
`timescale 1ns / 1ps

module png_scanline_unfilter #(
  parameter int MAX_ROW_BYTES       = psu_pkg::DEF_MAX_ROW_BYTES,
  parameter int MAX_BYTES_PER_PIXEL = psu_pkg::DEF_MAX_BYTES_PER_PIXEL
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  psu_pkg::psu_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output psu_pkg::psu_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [psu_pkg::BPP_W-1:0] cfg_wdata
);

  import psu_pkg::*;

  localparam int POS_W = $clog2(MAX_ROW_BYTES);
  localparam int IDX_W = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;

  logic             push;
  psu_entry_t       entry;
  logic [POS_W-1:0] pos;
  logic [IDX_W-1:0] bpp_idx;
  logic             s1_free;
  logic             mem_we;
  logic [POS_W-1:0] mem_waddr;
  logic [PIX_W-1:0] mem_wdata;
  logic [PIX_W-1:0] above_byte;

  psu_ctrl #(
    .MAX_ROW_BYTES       (MAX_ROW_BYTES),
    .MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s1_free   (s1_free),
    .push      (push),
    .entry     (entry),
    .pos       (pos),
    .bpp_idx   (bpp_idx)
  );

  psu_row_mem #(
    .DEPTH (MAX_ROW_BYTES),
    .DW    (PIX_W)
  ) u_row_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (push),
    .raddr (pos),
    .rdata (above_byte)
  );

  psu_recon #(
    .MAX_ROW_BYTES       (MAX_ROW_BYTES),
    .MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
  ) u_recon (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .entry      (entry),
    .pos        (pos),
    .bpp_idx    (bpp_idx),
    .above_byte (above_byte),
    .s1_free    (s1_free),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[tb/sv/psu_checker.sv]
// Scoreboard for png_scanline_unfilter: watches both channels and the cfg port.
// Rebuilds every row byte from the accepted input transactions and compares it
// with the output transactions. Depends on psu_pkg.
`timescale 1ns / 1ps

module psu_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  psu_pkg::psu_in_t          in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  psu_pkg::psu_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [psu_pkg::BPP_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending,
  output int                        results_seen
);

  import psu_pkg::*;

  localparam int ROW_MAX = DEF_MAX_ROW_BYTES;
  localparam int BPP_MAX = DEF_MAX_BYTES_PER_PIXEL;

  logic [PIX_W-1:0] prior_row [ROW_MAX];
  logic [PIX_W-1:0] left_bytes [8];
  logic [PIX_W-1:0] upleft_bytes [8];
  filt_t            row_filt;
  int unsigned      col;
  int unsigned      row_len;
  bit               no_above;
  bit               at_row_start;
  logic [BPP_W-1:0] bpp_reg;

  psu_out_t expected_pixels [$];
  int       mismatches = 0;
  int       compared = 0;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
  end

  function automatic logic [PIX_W-1:0] paeth_pick(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                                  logic [PIX_W-1:0] c);
    int p, pa, pb, pc;
    p  = int'(a) + int'(b) - int'(c);
    pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
    pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
    pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  task automatic clear_state();
    for (int k = 0; k < 8; k++) begin
      left_bytes[k]   = '0;
      upleft_bytes[k] = '0;
    end
    row_filt     = FILT_NONE;
    col          = 0;
    row_len      = 0;
    no_above     = 1'b1;
    at_row_start = 1'b1;
    bpp_reg      = 4'd1;
  endtask

  // Filter byte only loads row context; data bytes queue one expected pixel.
  task automatic reconstruct(input psu_in_t t);
    int unsigned      span;
    logic [PIX_W-1:0] a, b, c, pred, res;
    psu_out_t         want;
    if (at_row_start) begin
      if (t.row_bytes == 0) row_len = 1;
      else if (t.row_bytes > ROW_MAX) row_len = ROW_MAX;
      else row_len = t.row_bytes;
      row_filt = (t.raw_byte > 8'd4) ? FILT_NONE : filt_t'(t.raw_byte[2:0]);
      no_above = t.new_pass;
      col      = 0;
      for (int k = 0; k < 8; k++) begin
        left_bytes[k]   = '0;
        upleft_bytes[k] = '0;
      end
      at_row_start = 1'b0;
    end else begin
      if (bpp_reg == 0) span = 1;
      else if (bpp_reg > BPP_MAX) span = BPP_MAX;
      else span = bpp_reg;
      b = no_above ? '0 : prior_row[col];
      a = (col >= span) ? left_bytes[span-1] : '0;
      c = (col >= span && !no_above) ? upleft_bytes[span-1] : '0;
      case (row_filt)
        FILT_SUB:   pred = a;
        FILT_UP:    pred = b;
        FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
        FILT_PAETH: pred = paeth_pick(a, b, c);
        default:    pred = '0;
      endcase
      res = t.raw_byte + pred;
      for (int k = 7; k > 0; k--) begin
        left_bytes[k]   = left_bytes[k-1];
        upleft_bytes[k] = upleft_bytes[k-1];
      end
      left_bytes[0]   = res;
      upleft_bytes[0] = b;
      prior_row[col]  = res;
      col++;
      want.pixel_byte = res;
      want.row_end    = (col >= row_len);
      if (want.row_end) begin
        at_row_start = 1'b1;
        col          = 0;
      end
      expected_pixels = {expected_pixels, want};
    end
  endtask

  always @(posedge clk) begin : monitor
    psu_out_t want;
    if (!rst_n) begin
      clear_state();
      expected_pixels.delete();
    end else begin
      if (in_valid && in_ready) reconstruct(in_data);
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected output transaction, expected none,",
                   $time);
          $display("    got pixel_byte %02h row_end %0b",
                   out_data.pixel_byte, out_data.row_end);
        end else begin
          want = expected_pixels.pop_front();
          compared++;
          if (out_data.pixel_byte !== want.pixel_byte) begin
            mismatches++;
            $display("%0t: pixel_byte mismatch, expected %02h, got %02h",
                     $time, want.pixel_byte, out_data.pixel_byte);
          end
          if (out_data.row_end !== want.row_end) begin
            mismatches++;
            $display("%0t: row_end mismatch, expected %0b, got %0b",
                     $time, want.row_end, out_data.row_end);
          end
        end
      end
      if (cfg_we) bpp_reg = cfg_wdata;
    end
    // registered copies, so the top reads them free of races
    pending      <= expected_pixels.size();
    fail_count   <= mismatches;
    results_seen <= compared;
  end

endmodule

[tb/sv/tb_top.sv]
// Top of the png_scanline_unfilter testbench: clock, reset, stimulus, verdict.
// Drives rows of filter and data bytes with random idling on both channels;
// depends on psu_pkg, png_scanline_unfilter and psu_checker.
`timescale 1ns / 1ps

module tb_top;

  import psu_pkg::*;

  localparam int ROW_MAX    = DEF_MAX_ROW_BYTES;
  localparam int STALL_LIMIT = 200;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  psu_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  psu_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [BPP_W-1:0]     cfg_wdata = '0;

  int fail_count;
  int pending;
  int results_seen;

  int items_sent = 0;
  int rows_sent = 0;
  int cfg_writes = 0;
  int above_extent = 0;   // longest row written since reset
  int src_burst = 0;
  int sink_burst = 0;
  int quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  png_scanline_unfilter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  psu_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // Random idle gaps, with occasional stretches of back-to-back traffic
  function automatic int draw_idle(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      burst = $urandom_range(15, 60);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  task automatic send_item(input psu_in_t item);
    int idle;
    idle = draw_idle(src_burst);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Wait for the pipeline to empty, then write bytes_per_pixel.
  task automatic drain_and_write(input logic [BPP_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);  // pending is a registered copy and lags behind the last acceptance
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [RAW_W-1:0] data_byte(input bit edge_pat, input int idx);
    if (edge_pat) begin
      case (idx % 4)
        0:       return 8'hFF;
        1:       return 8'h00;
        2:       return 8'h80;
        default: return 8'h7F;
      endcase
    end
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One row: filter transaction, then its data bytes. A row that would read
  // above-row bytes never written since reset is flagged as a new pass.
  task automatic send_row(input logic [RAW_W-1:0] ftype, input bit np,
                          input logic [ROWB_W-1:0] rb, input bit edge_pat,
                          input int cfg_at, input logic [BPP_W-1:0] cfg_mid);
    int      len;
    psu_in_t item;
    if (rb == 0) len = 1;
    else if (rb > ROW_MAX) len = ROW_MAX;
    else len = rb;
    if (!np && len > above_extent) np = 1'b1;
    item.raw_byte  = ftype;
    item.new_pass  = np;
    item.row_bytes = rb;
    send_item(item);
    for (int i = 0; i < len; i++) begin
      if (i == cfg_at) drain_and_write(cfg_mid);
      item.raw_byte  = data_byte(edge_pat, i);
      item.new_pass  = 1'($urandom_range(0, 1));   // ignored on data bytes
      item.row_bytes = 14'($urandom_range(0, 16383));
      send_item(item);
    end
    if (len > above_extent) above_extent = len;
    rows_sent++;
  endtask

  function automatic logic [RAW_W-1:0] rand_filter();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(5, 255));
    return 8'($urandom_range(0, 4));
  endfunction

  function automatic logic [ROWB_W-1:0] rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 80) return 14'($urandom_range(1, 16));
    if (r < 95) return 14'($urandom_range(17, 64));
    return 14'($urandom_range(65, 300));
  endfunction

  // watchdog: cycles without any accepted transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: %0d cycles with no transaction, %0d results outstanding",
                 quiet_cycles, pending);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : sink
    int idle;
    while (!rst_n) @(posedge clk);
    forever begin
      idle = draw_idle(sink_burst);
      if (idle > 0) begin
        out_ready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic [BPP_W-1:0] cfg_plan [8];
    int               start;
    cfg_plan = '{4'd15, 4'd8, 4'd2, 4'd0, 4'd5, 4'd1, 4'd7, 4'd3};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every filter, zero length, mid-row bpp change, unknown type,
    // Paeth on the first row of a pass
    drain_and_write(4'd3);
    send_row(8'(FILT_NONE), 1'b1, 14'd0, 1'b1, -1, '0);
    send_row(8'(FILT_SUB), 1'b1, 14'd4, 1'b1, -1, '0);
    send_row(8'(FILT_UP), 1'b0, 14'd4, 1'b1, -1, '0);
    send_row(8'(FILT_AVG), 1'b0, 14'd4, 1'b1, 2, 4'd1);
    send_row(8'(FILT_PAETH), 1'b0, 14'd4, 1'b1, -1, '0);
    send_row(8'hFF, 1'b0, 14'd2, 1'b1, -1, '0);
    send_row(8'(FILT_PAETH), 1'b1, 14'd4, 1'b1, -1, '0);

    for (int ph = 0; ph < 8; ph++) begin
      drain_and_write(ph == 7 ? 4'($urandom_range(0, 15)) : cfg_plan[ph]);
      start = items_sent;
      while (items_sent - start < 80)
        send_row(rand_filter(), $urandom_range(0, 3) == 0, rand_len(), 1'b0, -1, '0);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d input transactions in %0d rows across %0d bytes_per_pixel settings;",
             items_sent, rows_sent, cfg_writes);
    $display("compared %0d reconstructed bytes, %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[png_scanline_unfilter.f]
hw/rtl/psu_pkg.sv
hw/rtl/psu_row_mem.sv
hw/rtl/psu_ctrl.sv
hw/rtl/psu_recon.sv
hw/rtl/png_scanline_unfilter.sv
tb/sv/psu_checker.sv
tb/sv/tb_top.sv
